// ----- sv/bol3_pkg.sv -----
// ----------------------------------------------------------------------------
// bol3_pkg: shared types, constants and elaboration-time table functions
// 64-bit turn-unit angles (2^64 = 2pi), Q3.60 sines, cosines and products.
// ----------------------------------------------------------------------------
package bol3_pkg;

    typedef logic [63:0] t_word;

    typedef struct packed {
        t_word x;
        t_word y;
        t_word z;
    } t_rot;

    localparam t_word ONE_Q       = 64'h1000_0000_0000_0000;
    localparam t_word TURN_HALF   = 64'h8000_0000_0000_0000;
    localparam t_word TURN_QUART  = 64'h4000_0000_0000_0000;
    localparam t_word TWO_OVER_PI = 64'hA2F9_836E_4E44_1529;
    localparam t_word RHO_EPS     = 64'd2935890503282;

    // restoring division, used only while elaborating constants
    function automatic t_word f_udiv(input t_word n, input t_word d);
        logic [64:0] r;
        t_word       q;
        r = '0;
        q = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d}) begin
                r    = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-i) in turn units, truncated (series in Q62, then scaled by 2/pi)
    function automatic t_word f_atan(input int unsigned i);
        t_word        sum;
        t_word        term;
        logic [127:0] p;
        int unsigned  e;
        logic         done;
        sum  = '0;
        done = 1'b0;
        for (int unsigned k = 0; k < 64; k++) begin
            e = (2 * k + 1) * i;
            if (e > 62) begin
                done = 1'b1;
            end
            if (!done) begin
                term = f_udiv(t_word'(1) << (62 - e), t_word'(2 * k + 1));
                sum  = k[0] ? sum - term : sum + term;
            end
        end
        p = {64'd0, sum} * {64'd0, TWO_OVER_PI};
        return (i == 0) ? (TURN_QUART >> 1) : p[127:64];
    endfunction

    // floor(2^120 / G), G = x result of vectoring (1, 0)
    function automatic t_word f_gain_inv(input int unsigned n);
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        t_word              r;
        t_word              q;
        x = ONE_Q;
        y = '0;
        for (int unsigned i = 0; i < n; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (!y[63]) begin
                x = x + dx;
                y = y - dy;
            end else begin
                x = x - dx;
                y = y + dy;
            end
        end
        r = ONE_Q;
        q = '0;
        for (int unsigned i = 0; i < 60; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= t_word'(x)) begin
                r    = r - t_word'(x);
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

endpackage

// ----- sv/bol3_if.sv -----
// ----------------------------------------------------------------------------
// bol3 stream interfaces
// Valid/ready channels carrying one input item and one result item.
// ----------------------------------------------------------------------------
interface bol3_in_if #(parameter int ANGLE_BITS = 32);
    logic                         valid;
    logic                         ready;
    logic signed [ANGLE_BITS-1:0] centre_ra;
    logic signed [ANGLE_BITS-1:0] centre_dec;
    logic signed [ANGLE_BITS-1:0] centre_angle;
    logic signed [ANGLE_BITS-1:0] pixel_ra;
    logic signed [ANGLE_BITS-1:0] pixel_dec;

    modport source (output valid, centre_ra, centre_dec, centre_angle, pixel_ra, pixel_dec,
                    input ready);
    modport sink   (input valid, centre_ra, centre_dec, centre_angle, pixel_ra, pixel_dec,
                    output ready);
endinterface

interface bol3_out_if #(parameter int ANGLE_BITS = 32);
    logic                         valid;
    logic                         ready;
    logic        [ANGLE_BITS-1:0] radial_offset;
    logic        [ANGLE_BITS-1:0] polar_offset;
    logic signed [ANGLE_BITS-1:0] copol_angle;

    modport source (output valid, radial_offset, polar_offset, copol_angle, input ready);
    modport sink   (input valid, radial_offset, polar_offset, copol_angle, output ready);
endinterface

// ----- sv/bol3_delay.sv -----
// ----------------------------------------------------------------------------
// bol3_delay: payload shift line
// DEPTH registers advancing together on enable.
// ----------------------------------------------------------------------------
module bol3_delay #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);
    logic [WIDTH-1:0] r_tap [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_tap[k] <= r_tap[k-1];
            end
        end
    end

    assign o_q = r_tap[DEPTH-1];
endmodule

// ----- sv/bol3_rot_cell.sv -----
// ----------------------------------------------------------------------------
// bol3_rot_cell: one CORDIC micro-rotation
// Rotation mode steers on z, vectoring mode on y; result registered.
// ----------------------------------------------------------------------------
module bol3_rot_cell #(
    parameter int unsigned SHIFT = 0,
    parameter bit          VEC   = 1'b0
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  bol3_pkg::t_rot i_v,
    output bol3_pkg::t_rot o_v
);
    import bol3_pkg::*;

    localparam t_word ATAN = f_atan(SHIFT);

    t_word dx;
    t_word dy;
    logic  up;
    t_rot  r_v;

    assign dx = t_word'($signed(i_v.y) >>> SHIFT);
    assign dy = t_word'($signed(i_v.x) >>> SHIFT);
    assign up = VEC ? i_v.y[63] : !i_v.z[63];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (up) begin
                r_v <= '{x: i_v.x - dx, y: i_v.y + dy, z: i_v.z - ATAN};
            end else begin
                r_v <= '{x: i_v.x + dx, y: i_v.y - dy, z: i_v.z + ATAN};
            end
        end
    end

    assign o_v = r_v;
endmodule

// ----- sv/bol3_cordic.sv -----
// ----------------------------------------------------------------------------
// bol3_cordic: row of CORDIC cells
// STAGES cells, each handing x, y, z to the next every cycle that i_en is high.
// ----------------------------------------------------------------------------
module bol3_cordic #(
    parameter int unsigned STAGES = 28,
    parameter bit          VEC    = 1'b0
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  bol3_pkg::t_rot i_v,
    output bol3_pkg::t_rot o_v
);
    import bol3_pkg::*;

    t_rot w_s [STAGES+1];

    assign w_s[0] = i_v;

    for (genvar g = 0; g < STAGES; g++) begin : g_cell
        bol3_rot_cell #(.SHIFT(g), .VEC(VEC)) u_cell (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_v   (w_s[g]),
            .o_v   (w_s[g+1])
        );
    end

    assign o_v = w_s[STAGES];
endmodule

// ----- sv/bol3_mulq.sv -----
// ----------------------------------------------------------------------------
// bol3_mulq: Q60 signed multiply, magnitude truncated
// Two stages: four 32x32 partial products, then sum, select and sign.
// ----------------------------------------------------------------------------
module bol3_mulq (
    input  logic            i_clk,
    input  logic            i_en,
    input  bol3_pkg::t_word i_a,
    input  bol3_pkg::t_word i_b,
    output bol3_pkg::t_word o_p
);
    import bol3_pkg::*;

    t_word        ua;
    t_word        ub;
    t_word        r_ll;
    t_word        r_lh;
    t_word        r_hl;
    t_word        r_hh;
    logic         r_neg;
    logic [127:0] full;
    t_word        mag;
    t_word        r_p;

    assign ua = i_a[63] ? t_word'(0) - i_a : i_a;
    assign ub = i_b[63] ? t_word'(0) - i_b : i_b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll  <= ua[31:0]  * ub[31:0];
            r_lh  <= ua[31:0]  * ub[63:32];
            r_hl  <= ua[63:32] * ub[31:0];
            r_hh  <= ua[63:32] * ub[63:32];
            r_neg <= i_a[63] ^ i_b[63];
        end
    end

    assign full = {r_hh, r_ll} + {32'd0, r_lh, 32'd0} + {32'd0, r_hl, 32'd0};
    assign mag  = full[123:60];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= r_neg ? t_word'(0) - mag : mag;
        end
    end

    assign o_p = r_p;
endmodule

// ----- sv/beam_offset_ludwig3_angles_top.sv -----
// ----------------------------------------------------------------------------
// beam_offset_ludwig3_angles_top: beam offset and Ludwig-3 co-polar angle
// Rho, sigma and chi of a pixel relative to a beam centre, fully pipelined.
// ----------------------------------------------------------------------------
// One item is taken per clock while the pipeline is not stalled. Results
// come from three CORDIC cell rows in series (sin/cos, then atan2 for alpha
// and beta, then atan2 for rho) and three levels of two-stage 64-bit
// multipliers. The pipeline only stalls when its last stage holds a result
// and the output register is full and not being taken; bubbles keep moving,
// so new transfers are taken while a finished result waits downstream.
// Angles are binary angles with 2^(ANGLE_BITS-1) = pi; internally all
// angles are 64-bit turn units and trig values Q3.60.
module beam_offset_ludwig3_angles_top #(
    parameter int ANGLE_BITS    = 32,
    parameter int CORDIC_STAGES = 28
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bol3_in_if.sink           i_in,
    bol3_out_if.source        o_out
);
    import bol3_pkg::*;

    localparam int    IO_SHIFT = 64 - ANGLE_BITS;
    localparam int    N        = CORDIC_STAGES;
    localparam int    LAT      = 3 * N + 11;   // valid pipeline stages
    localparam t_word GAIN_INV = f_gain_inv(CORDIC_STAGES);

    // ---------------- flow control ----------------
    logic           en;          // whole pipeline advances
    logic           in_fire;
    logic           load;        // last stage moves into output register
    logic [LAT-1:0] r_vld;
    logic           r_out_valid;

    assign en      = !r_vld[LAT-1] || !r_out_valid || o_out.ready;
    assign in_fire = i_in.valid && en;
    assign load    = r_vld[LAT-1] && en;
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (en) begin
                r_vld <= {r_vld[LAT-2:0], in_fire};
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------- stage 1: sin/cos setup ----------------
    // 0: centre dec, 1: pixel dec, 2: ra difference
    t_word w_ang [3];
    logic  w_flip [3];
    t_rot  r_sc [3];
    logic  [2:0] r_flip;
    t_word r_psi;

    assign w_ang[0] = {i_in.centre_dec, {IO_SHIFT{1'b0}}};
    assign w_ang[1] = {i_in.pixel_dec,  {IO_SHIFT{1'b0}}};
    assign w_ang[2] = {i_in.pixel_ra,   {IO_SHIFT{1'b0}}}
                    - {i_in.centre_ra,  {IO_SHIFT{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                // second and third quadrant: rotate by half a turn, negate after
                r_sc[k]   <= '{x: GAIN_INV, y: '0,
                               z: w_flip[k] ? w_ang[k] + TURN_HALF : w_ang[k]};
                r_flip[k] <= w_flip[k];
            end
            r_psi <= {i_in.centre_angle, {IO_SHIFT{1'b0}}};
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_flip
        assign w_flip[g] = w_ang[g][63] ^ w_ang[g][62];
    end

    t_rot        w_sc_o [3];
    logic [2:0]  flip_d;

    for (genvar g = 0; g < 3; g++) begin : g_sc
        bol3_cordic #(.STAGES(N), .VEC(1'b0)) u_sc (
            .i_clk (i_clk), .i_en (en), .i_v (r_sc[g]), .o_v (w_sc_o[g])
        );
    end

    bol3_delay #(.WIDTH(3), .DEPTH(N)) u_flip_d (
        .i_clk (i_clk), .i_en (en), .i_d (r_flip), .o_q (flip_d)
    );

    // ---------------- stage N+2: quadrant fix ----------------
    t_word r_cos [3];
    t_word r_sin [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_cos[k] <= flip_d[k] ? t_word'(0) - w_sc_o[k].x : w_sc_o[k].x;
                r_sin[k] <= flip_d[k] ? t_word'(0) - w_sc_o[k].y : w_sc_o[k].y;
            end
        end
    end

    // ---------------- first product level ----------------
    t_word p_a, p_b, p_c, p_d, p_ya, p_yb;

    bol3_mulq u_ma (.i_clk(i_clk), .i_en(en), .i_a(r_sin[0]), .i_b(r_sin[1]), .o_p(p_a));
    bol3_mulq u_mb (.i_clk(i_clk), .i_en(en), .i_a(r_cos[0]), .i_b(r_cos[1]), .o_p(p_b));
    bol3_mulq u_mc (.i_clk(i_clk), .i_en(en), .i_a(r_sin[1]), .i_b(r_cos[0]), .o_p(p_c));
    bol3_mulq u_md (.i_clk(i_clk), .i_en(en), .i_a(r_cos[1]), .i_b(r_sin[0]), .o_p(p_d));
    bol3_mulq u_my (.i_clk(i_clk), .i_en(en), .i_a(r_sin[2]), .i_b(r_cos[1]), .o_p(p_ya));
    bol3_mulq u_mz (.i_clk(i_clk), .i_en(en), .i_a(r_sin[2]), .i_b(r_cos[0]), .o_p(p_yb));

    t_word cd_d;

    bol3_delay #(.WIDTH(64), .DEPTH(2)) u_cd_d (
        .i_clk (i_clk), .i_en (en), .i_d (r_cos[2]), .o_q (cd_d)
    );

    // ---------------- second product level ----------------
    t_word q_b, q_c, q_d;
    t_word a_d, c_d, d_d, ya_d, yb_d;

    bol3_mulq u_qb (.i_clk(i_clk), .i_en(en), .i_a(p_b), .i_b(cd_d), .o_p(q_b));
    bol3_mulq u_qc (.i_clk(i_clk), .i_en(en), .i_a(p_c), .i_b(cd_d), .o_p(q_c));
    bol3_mulq u_qd (.i_clk(i_clk), .i_en(en), .i_a(p_d), .i_b(cd_d), .o_p(q_d));

    bol3_delay #(.WIDTH(320), .DEPTH(2)) u_p_d (
        .i_clk (i_clk), .i_en (en),
        .i_d   ({p_a, p_c, p_d, p_ya, p_yb}),
        .o_q   ({a_d, c_d, d_d, ya_d, yb_d})
    );

    // ---------------- stage N+7: sums ----------------
    t_word r_crho, r_xa, r_xb, r_ya, r_yb;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_crho <= a_d + q_b;
            r_xa   <= c_d - q_d;
            r_xb   <= d_d - q_c;
            r_ya   <= ya_d;
            r_yb   <= yb_d;
        end
    end

    // ---------------- atan2 for alpha and beta ----------------
    t_rot r_va, r_vb;

    always_ff @(posedge i_clk) begin
        if (en) begin
            // left half plane: negate vector, start from half a turn
            if (r_xa[63]) begin
                r_va <= '{x: t_word'(0) - r_xa, y: t_word'(0) - r_ya, z: TURN_HALF};
            end else begin
                r_va <= '{x: r_xa, y: r_ya, z: '0};
            end
            if (r_xb[63]) begin
                r_vb <= '{x: t_word'(0) - r_xb, y: t_word'(0) - r_yb, z: TURN_HALF};
            end else begin
                r_vb <= '{x: r_xb, y: r_yb, z: '0};
            end
        end
    end

    t_rot va_o, vb_o;

    bol3_cordic #(.STAGES(N), .VEC(1'b1)) u_va (
        .i_clk (i_clk), .i_en (en), .i_v (r_va), .o_v (va_o)
    );
    bol3_cordic #(.STAGES(N), .VEC(1'b1)) u_vb (
        .i_clk (i_clk), .i_en (en), .i_v (r_vb), .o_v (vb_o)
    );

    // sin(rho) from the alpha vector magnitude
    t_word srho;
    t_word crho_d;

    bol3_mulq u_ms (.i_clk(i_clk), .i_en(en), .i_a(va_o.x), .i_b(GAIN_INV), .o_p(srho));

    bol3_delay #(.WIDTH(64), .DEPTH(N + 3)) u_crho_d (
        .i_clk (i_clk), .i_en (en), .i_d (r_crho), .o_q (crho_d)
    );

    // ---------------- atan2 for rho ----------------
    t_rot r_vr;
    logic r_ge1;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ge1 <= !crho_d[63] && (crho_d >= ONE_Q);
            if (crho_d[63]) begin
                r_vr <= '{x: t_word'(0) - crho_d, y: t_word'(0) - srho, z: TURN_HALF};
            end else begin
                r_vr <= '{x: crho_d, y: srho, z: '0};
            end
        end
    end

    t_rot  vr_o;
    logic  ge1_d;
    t_word alpha_d, beta_d, psi_d;

    bol3_cordic #(.STAGES(N), .VEC(1'b1)) u_vr (
        .i_clk (i_clk), .i_en (en), .i_v (r_vr), .o_v (vr_o)
    );

    bol3_delay #(.WIDTH(1), .DEPTH(N)) u_ge1_d (
        .i_clk (i_clk), .i_en (en), .i_d (r_ge1), .o_q (ge1_d)
    );
    bol3_delay #(.WIDTH(128), .DEPTH(N + 3)) u_ab_d (
        .i_clk (i_clk), .i_en (en), .i_d ({va_o.z, vb_o.z}), .o_q ({alpha_d, beta_d})
    );
    bol3_delay #(.WIDTH(64), .DEPTH(3 * N + 10)) u_psi_d (
        .i_clk (i_clk), .i_en (en), .i_d (r_psi), .o_q (psi_d)
    );

    // ---------------- final stage ----------------
    t_word rho, alpha_f, beta_f, sigma, chi;

    always_comb begin
        if (ge1_d) begin
            rho = '0;                       // cosine at least one
        end else if (vr_o.z > TURN_HALF) begin
            // residue past pi: fold back to 0 or clamp at pi
            rho = (vr_o.z >= TURN_HALF + TURN_QUART) ? t_word'(0) : TURN_HALF;
        end else begin
            rho = vr_o.z;
        end
        // pixel on the beam axis: orientation undefined, use pi/2
        alpha_f = (rho <= RHO_EPS) ? TURN_QUART : alpha_d;
        beta_f  = (rho <= RHO_EPS) ? TURN_QUART : beta_d;
        sigma   = TURN_HALF - alpha_f - psi_d;
        chi     = beta_f - sigma;
    end

    logic [ANGLE_BITS:0] rnd_rho, rnd_sig, rnd_chi;

    assign rnd_rho = rho[63:IO_SHIFT-1]   + (ANGLE_BITS+1)'(1);
    assign rnd_sig = sigma[63:IO_SHIFT-1] + (ANGLE_BITS+1)'(1);
    assign rnd_chi = chi[63:IO_SHIFT-1]   + (ANGLE_BITS+1)'(1);

    logic [ANGLE_BITS-1:0] r_rho, r_sig, r_chi;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rho <= rnd_rho[ANGLE_BITS:1];
            r_sig <= rnd_sig[ANGLE_BITS:1];
            r_chi <= rnd_chi[ANGLE_BITS:1];
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.radial_offset = r_rho;
    assign o_out.polar_offset  = r_sig;
    assign o_out.copol_angle   = $signed(r_chi);

    // ---------------- assertions ----------------
    a_fire_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_vld[0])
        else $error("accepted transfer did not enter the pipeline");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("pipeline moved while stalled");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> r_out_valid && !o_out.ready && r_vld[LAT-1])
        else $error("input held off without a blocked result");

    a_rho_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_rho <= (ANGLE_BITS)'(1) << (ANGLE_BITS - 1)))
        else $error("radial offset beyond pi");
endmodule

// ----- tb/beam_offset_ludwig3_angles_top_test.sv -----
// ----------------------------------------------------------------------------
// beam_offset_ludwig3_angles_top_test: self-checking bench for the beam offset
// Drives pointing pairs through the stream input and checks rho, sigma and chi
// of every transfer against a bit-true CORDIC predictor or typed-in values.
// The sender works in bursts and the receiver stalls at random.
// ----------------------------------------------------------------------------
module beam_offset_ludwig3_angles_top_test;
    import bol3_pkg::*;

    localparam int AB     = 32;
    localparam int STAGES = 28;
    localparam int LAT    = 3 * STAGES + 12;
    localparam int N_RAND = 1600;

    // one pointing pair
    typedef struct packed {
        logic [AB-1:0] c_ra;
        logic [AB-1:0] c_dec;
        logic [AB-1:0] c_ang;
        logic [AB-1:0] p_ra;
        logic [AB-1:0] p_dec;
    } t_pair;

    // one set of offset angles
    typedef struct packed {
        logic [AB-1:0] rho;
        logic [AB-1:0] sigma;
        logic [AB-1:0] chi;
    } t_offs;

    // directed row: fields marked in 'known' carry a typed-in value (rho, sigma, chi)
    typedef struct packed {
        t_pair      pair;
        logic [2:0] known;
        t_offs      offs;
    } t_row;

    localparam logic [AB-1:0] Q90  = 32'h4000_0000;
    localparam logic [AB-1:0] M90  = 32'hC000_0000;
    localparam logic [AB-1:0] P180 = 32'h8000_0000;
    localparam logic [AB-1:0] MAXP = 32'h7FFF_FFFF;
    localparam logic [AB-1:0] ALL1 = 32'hFFFF_FFFF;

    logic i_clk;
    logic i_rst_n;

    bol3_in_if  #(.ANGLE_BITS(AB)) in_ch ();
    bol3_out_if #(.ANGLE_BITS(AB)) out_ch ();

    beam_offset_ludwig3_angles_top #(
        .ANGLE_BITS   (AB),
        .CORDIC_STAGES(STAGES)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    // ------------------------------------------------------------------------
    // Predictor: 64-bit turn units, Q3.60 trig values
    // ------------------------------------------------------------------------
    logic [63:0] atan_lut [STAGES];
    logic [63:0] inv_gain;

    function automatic logic [63:0] sra64(input logic [63:0] v, input int s);
        return $signed(v) >>> s;
    endfunction

    // product in Q60, magnitude truncated toward zero
    function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [127:0] p;
        logic [63:0]  r;
        ua = a[63] ? -a : a;
        ub = b[63] ? -b : b;
        p  = {64'd0, ua} * {64'd0, ub};
        r  = p[123:60];
        return (a[63] ^ b[63]) ? -r : r;
    endfunction

    function automatic logic [63:0] atan_turns(input int i);
        logic [63:0]  sum;
        logic [63:0]  term;
        logic [127:0] p;
        int           e;
        sum = '0;
        for (int k = 0; k < 64; k++) begin
            e = (2 * k + 1) * i;
            if (e > 62) break;
            term = (64'd1 << (62 - e)) / 64'(2 * k + 1);
            sum  = k[0] ? sum - term : sum + term;
        end
        p = {64'd0, sum} * {64'd0, TWO_OVER_PI};
        return (i == 0) ? (TURN_QUART >> 1) : p[127:64];
    endfunction

    // vectoring: angle of (x, y), scaled magnitude in mag
    task automatic cordic_vec(input logic [63:0] xi, input logic [63:0] yi,
                              output logic [63:0] ang, output logic [63:0] mag);
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] z;
        logic [63:0] dx;
        logic [63:0] dy;
        x = xi;
        y = yi;
        z = '0;
        if (x[63]) begin
            x = -x;
            y = -y;
            z = TURN_HALF;
        end
        for (int i = 0; i < STAGES; i++) begin
            dx = sra64(y, i);
            dy = sra64(x, i);
            if (!y[63]) begin
                x = x + dx; y = y - dy; z = z + atan_lut[i];
            end else begin
                x = x - dx; y = y + dy; z = z - atan_lut[i];
            end
        end
        ang = z;
        mag = x;
    endtask

    task automatic cordic_rot(input logic [63:0] a, output logic [63:0] c,
                              output logic [63:0] s);
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] z;
        logic [63:0] dx;
        logic [63:0] dy;
        logic        flip;
        x    = inv_gain;
        y    = '0;
        flip = (a[63:62] == 2'd1) || (a[63:62] == 2'd2);
        z    = flip ? a + TURN_HALF : a;
        for (int i = 0; i < STAGES; i++) begin
            dx = sra64(y, i);
            dy = sra64(x, i);
            if (!z[63]) begin
                x = x - dx; y = y + dy; z = z - atan_lut[i];
            end else begin
                x = x + dx; y = y - dy; z = z + atan_lut[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    task automatic build_tables();
        logic [63:0] g;
        logic [63:0] dummy;
        logic [63:0] r;
        logic [63:0] q;
        for (int i = 0; i < STAGES; i++) atan_lut[i] = atan_turns(i);
        cordic_vec(ONE_Q, 64'd0, dummy, g);
        r = ONE_Q;
        q = '0;
        for (int i = 0; i < 60; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= g) begin
                r    = r - g;
                q[0] = 1'b1;
            end
        end
        inv_gain = q;
    endtask

    function automatic logic [AB-1:0] to_io(input logic [63:0] v);
        logic [63:0] t;
        t = ((v >> (64 - AB - 1)) + 64'd1) >> 1;
        return t[AB-1:0];
    endfunction

    task automatic offsets_of(input t_pair pr, output t_offs o);
        logic [63:0] rac, decc, psic, rap, decp;
        logic [63:0] cdc, sdc, cdp, sdp, cd, sd;
        logic [63:0] crho, xa, ya, xb, yb;
        logic [63:0] alpha, beta, maga, rho, sigma, chi, unused;
        rac  = {pr.c_ra,  32'd0};
        decc = {pr.c_dec, 32'd0};
        psic = {pr.c_ang, 32'd0};
        rap  = {pr.p_ra,  32'd0};
        decp = {pr.p_dec, 32'd0};
        cordic_rot(decc, cdc, sdc);
        cordic_rot(decp, cdp, sdp);
        cordic_rot(rap - rac, cd, sd);
        crho = qmul(sdc, sdp) + qmul(qmul(cdc, cdp), cd);
        ya   = qmul(sd, cdp);
        xa   = qmul(sdp, cdc) - qmul(qmul(cdp, sdc), cd);
        yb   = qmul(sd, cdc);
        xb   = qmul(sdc, cdp) - qmul(qmul(cdc, sdp), cd);
        cordic_vec(xa, ya, alpha, maga);
        cordic_vec(xb, yb, beta, unused);
        if (!crho[63] && crho >= ONE_Q) begin
            rho = '0;
        end else begin
            cordic_vec(crho, qmul(maga, inv_gain), rho, unused);
            // CORDIC residue past pi or below zero
            if (rho > TURN_HALF) rho = (rho >= TURN_HALF + TURN_QUART) ? 64'd0 : TURN_HALF;
        end
        // pixel on the beam centre: position angles fixed at pi/2
        if (rho <= RHO_EPS) begin
            alpha = TURN_QUART;
            beta  = TURN_QUART;
        end
        sigma   = TURN_HALF - alpha - psic;
        chi     = beta - sigma;
        o.rho   = to_io(rho);
        o.sigma = to_io(sigma);
        o.chi   = to_io(chi);
    endtask

    // ------------------------------------------------------------------------
    // Scoreboard
    // ------------------------------------------------------------------------
    t_offs pending_offs [$];
    int    n_err;
    int    n_sent;
    int    n_got;
    int    n_near;
    bit    rx_hold;
    bit    rx_free;

    // ------------------------------------------------------------------------
    // Clock, reset, limit
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("timeout: %0d offsets still outstanding", pending_offs.size());
        $display("Test completed with failures");
        $finish;
    end

    task automatic report(input string what, input logic [AB-1:0] got,
                          input logic [AB-1:0] want);
        n_err++;
        $display("mismatch at result %0d: %s got %h expected %h", n_got, what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_offs want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_offs.size() == 0) begin
                report("unexpected transfer", out_ch.radial_offset, '0);
            end else begin
                want = pending_offs.pop_front();
                if (out_ch.radial_offset !== want.rho)
                    report("radial_offset", out_ch.radial_offset, want.rho);
                if (out_ch.polar_offset !== want.sigma)
                    report("polar_offset", out_ch.polar_offset, want.sigma);
                if (out_ch.copol_angle !== want.chi)
                    report("copol_angle", out_ch.copol_angle, want.chi);
            end
            n_got++;
        end
    end

    // receiver: free-running stretches, random stalls, and a forced long hold
    always @(posedge i_clk) begin
        if (!i_rst_n)    out_ch.ready <= 1'b0;
        else if (rx_hold) out_ch.ready <= 1'b0;
        else if (rx_free) out_ch.ready <= 1'b1;
        else             out_ch.ready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge i_clk) begin
        if ($urandom_range(0, 199) == 0) rx_free <= ~rx_free;
    end

    // long hold-off once the random traffic is flowing, well past the latency
    initial begin
        rx_hold = 1'b0;
        wait (n_sent == 300);
        rx_hold = 1'b1;
        repeat (4 * LAT) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic send_pair(input t_pair pr, input t_row row, input bit typed);
        t_offs o;
        in_ch.valid        <= 1'b1;
        in_ch.centre_ra    <= pr.c_ra;
        in_ch.centre_dec   <= pr.c_dec;
        in_ch.centre_angle <= pr.c_ang;
        in_ch.pixel_ra     <= pr.p_ra;
        in_ch.pixel_dec    <= pr.p_dec;
        do @(posedge i_clk); while (!in_ch.ready);
        offsets_of(pr, o);
        if (typed) begin
            if (row.known[2]) o.rho   = row.offs.rho;
            if (row.known[1]) o.sigma = row.offs.sigma;
            if (row.known[0]) o.chi   = row.offs.chi;
        end
        pending_offs.push_back(o);
        n_sent++;
    endtask

    task automatic idle(input int n);
        if (n > 0) begin
            in_ch.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    function automatic t_pair random_pair();
        t_pair pr;
        int    mode;
        logic [AB-1:0] decs [5];
        decs = '{Q90, M90, 32'd0, P180, MAXP};
        pr   = {$urandom, $urandom, $urandom, $urandom, $urandom};
        mode = $urandom_range(0, 9);
        case (mode)
            5, 6: begin
                // pixel close to the centre, down into the on-centre zone
                pr.p_ra  = pr.c_ra + AB'($signed($urandom_range(0, 2000)) - 1000);
                pr.p_dec = pr.c_dec + AB'($signed($urandom_range(0, 2000)) - 1000);
                if ($urandom_range(0, 1)) pr.p_ra = pr.p_ra + ($urandom >> 10);
            end
            7: begin
                pr.c_dec = decs[$urandom_range(0, 4)];
                pr.p_dec = decs[$urandom_range(0, 4)];
            end
            8: begin
                pr.p_ra  = pr.c_ra;
                pr.p_dec = pr.c_dec;
            end
            9: begin
                pr.p_ra  = pr.c_ra + P180;
                pr.p_dec = -pr.c_dec;
            end
            default: ;
        endcase
        return pr;
    endfunction

    t_row dir_rows [] = '{
        // same point at the origin: on-centre, sigma pi/2, chi 0
        '{'{32'd0, 32'd0, 32'd0, 32'd0, 32'd0}, 3'b011, '{32'd0, Q90, 32'd0}},
        // same point, position angle pi/2
        '{'{32'd0, 32'd0, Q90, 32'd0, 32'd0}, 3'b011, '{32'd0, 32'd0, Q90}},
        // same point, position angle -pi: chi lands on pi and aliases to -pi
        '{'{32'd0, 32'd0, P180, 32'd0, 32'd0}, 3'b011, '{32'd0, M90, P180}},
        '{'{MAXP, MAXP, MAXP, MAXP, MAXP}, 3'b000, '{32'd0, 32'd0, 32'd0}},
        '{'{P180, P180, P180, P180, P180}, 3'b000, '{32'd0, 32'd0, 32'd0}},
        '{'{ALL1, ALL1, ALL1, ALL1, ALL1}, 3'b000, '{32'd0, 32'd0, 32'd0}},
        '{'{32'd0, 32'd0, 32'd0, MAXP, 32'd0}, 3'b000, '{32'd0, 32'd0, 32'd0}},
        '{'{P180, 32'd0, 32'd0, 32'd0, 32'd0}, 3'b000, '{32'd0, 32'd0, 32'd0}},
        '{'{32'd0, 32'd0, 32'd0, P180, 32'd0}, 3'b000, '{32'd0, 32'd0, 32'd0}},
        '{'{32'd0, Q90, 32'd0, 32'd0, M90}, 3'b000, '{32'd0, 32'd0, 32'd0}},
        '{'{32'd0, Q90, 32'd0, 32'h1234_5678, Q90}, 3'b000, '{32'd0, 32'd0, 32'd0}},
        '{'{32'd0, M90, 32'd0, Q90, M90}, 3'b000, '{32'd0, 32'd0, 32'd0}},
        '{'{32'd0, 32'h6000_0000, 32'd0, 32'd0, 32'hA000_0000}, 3'b000,
          '{32'd0, 32'd0, 32'd0}},
        '{'{32'd5, 32'd0, 32'd0, 32'd6, 32'd1}, 3'b000, '{32'd0, 32'd0, 32'd0}},
        '{'{32'd0, 32'd0, 32'd0, 32'd400, 32'd0}, 3'b000, '{32'd0, 32'd0, 32'd0}},
        '{'{32'd0, 32'd0, 32'd0, 32'd2000, 32'd0}, 3'b000, '{32'd0, 32'd0, 32'd0}},
        '{'{Q90, 32'h2000_0000, M90, M90, 32'hE000_0000}, 3'b000,
          '{32'd0, 32'd0, 32'd0}},
        '{'{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA},
          3'b000, '{32'd0, 32'd0, 32'd0}},
        '{'{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555},
          3'b000, '{32'd0, 32'd0, 32'd0}}
    };

    initial begin
        int burst;
        t_row none;
        none               = '0;
        n_err              = 0;
        n_sent             = 0;
        n_got              = 0;
        n_near             = 0;
        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.centre_ra    = '0;
        in_ch.centre_dec   = '0;
        in_ch.centre_angle = '0;
        in_ch.pixel_ra     = '0;
        in_ch.pixel_dec    = '0;
        build_tables();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, back to back with an occasional gap
        foreach (dir_rows[r]) begin
            send_pair(dir_rows[r].pair, dir_rows[r], 1'b1);
            idle($urandom_range(0, 1) * $urandom_range(1, 3));
        end

        // drain completely before the random traffic
        idle(1);
        while (pending_offs.size() != 0) @(posedge i_clk);

        // random traffic in bursts
        while (n_sent < dir_rows.size() + N_RAND) begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst; b++) begin
                t_pair pr;
                pr = random_pair();
                if (pr.p_ra - pr.c_ra + 32'd1000 <= 32'd2000) n_near++;
                send_pair(pr, none, 1'b0);
            end
            idle($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12));
        end
        idle(1);

        while (pending_offs.size() != 0) @(posedge i_clk);
        repeat (2 * LAT) @(posedge i_clk);

        $display("%0d pointing pairs sent (%0d directed, %0d near the centre), %0d results",
                 n_sent, dir_rows.size(), n_near, n_got);
        $display("traffic included bursts, receiver stalls, a long output hold and a full drain");
        if (n_err == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches", n_err);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
